@@ hw/rtl/kat_pkg.sv @@
// ----------------------------------------------------------------------------
// Kalman altitude tracker package
// Shared types, operation codes, operand codes, saturation helpers and the
// microprogram that the sequencer steps through.
// ----------------------------------------------------------------------------
package kat_pkg;

  // Arithmetic unit operations
  localparam logic [2:0] OP_MUL = 3'd0;
  localparam logic [2:0] OP_ADD = 3'd1;
  localparam logic [2:0] OP_SUB = 3'd2;
  localparam logic [2:0] OP_DIV = 3'd3;
  localparam logic [2:0] OP_RCP = 3'd4;
  localparam logic [2:0] OP_CMP = 3'd5;
  localparam logic [2:0] OP_END = 3'd6;

  // Saturation width selects
  localparam logic [1:0] W_EST = 2'd0;
  localparam logic [1:0] W_COV = 2'd1;
  localparam logic [1:0] W_64  = 2'd2;

  // Configuration register indexes
  localparam logic [2:0] CFG_TIME_STEP   = 3'd0;
  localparam logic [2:0] CFG_MEAS_VAR    = 3'd1;
  localparam logic [2:0] CFG_VAR_SUB     = 3'd2;
  localparam logic [2:0] CFG_VAR_TRA     = 3'd3;
  localparam logic [2:0] CFG_SPEED_THRSH = 3'd4;

  // Operand codes: below 32 is a register file entry, 32 and above are fixed sources
  localparam logic [5:0] R_P00 = 6'd0;
  localparam logic [5:0] R_P01 = 6'd1;
  localparam logic [5:0] R_P02 = 6'd2;
  localparam logic [5:0] R_P11 = 6'd3;
  localparam logic [5:0] R_P12 = 6'd4;
  localparam logic [5:0] R_P22 = 6'd5;
  localparam logic [5:0] R_S   = 6'd6;
  localparam logic [5:0] R_V   = 6'd7;
  localparam logic [5:0] R_A   = 6'd8;
  localparam logic [5:0] R09 = 6'd9;
  localparam logic [5:0] R10 = 6'd10;
  localparam logic [5:0] R11 = 6'd11;
  localparam logic [5:0] R12 = 6'd12;
  localparam logic [5:0] R13 = 6'd13;
  localparam logic [5:0] R14 = 6'd14;
  localparam logic [5:0] R15 = 6'd15;
  localparam logic [5:0] R16 = 6'd16;
  localparam logic [5:0] R17 = 6'd17;
  localparam logic [5:0] R18 = 6'd18;
  localparam logic [5:0] R19 = 6'd19;
  localparam logic [5:0] R20 = 6'd20;
  localparam logic [5:0] R21 = 6'd21;
  localparam logic [5:0] R22 = 6'd22;
  localparam logic [5:0] R23 = 6'd23;
  localparam logic [5:0] R24 = 6'd24;
  localparam logic [5:0] R25 = 6'd25;
  localparam logic [5:0] R26 = 6'd26;
  localparam logic [5:0] R27 = 6'd27;
  localparam logic [5:0] R28 = 6'd28;
  localparam logic [5:0] S_ZERO  = 6'd32;
  localparam logic [5:0] S_T16   = 6'd33;
  localparam logic [5:0] S_T     = 6'd34;
  localparam logic [5:0] S_VE    = 6'd35;
  localparam logic [5:0] S_VS    = 6'd36;
  localparam logic [5:0] S_VM    = 6'd37;
  localparam logic [5:0] S_MEAS  = 6'd38;
  localparam logic [5:0] S_C36   = 6'd39;
  localparam logic [5:0] S_C12   = 6'd40;
  localparam logic [5:0] S_C6    = 6'd41;
  localparam logic [5:0] S_C4    = 6'd42;
  localparam logic [5:0] S_C2    = 6'd43;
  localparam logic [5:0] S_ONE32 = 6'd44;
  localparam logic [5:0] S_TWO62 = 6'd45;
  localparam logic [5:0] S_THRSH = 6'd46;

  localparam logic [6:0] PC_RESET = 7'd0;
  localparam logic [6:0] PC_MEAS  = 7'd24;

  typedef struct packed {
    logic [2:0] op;
    logic [4:0] dst;
    logic [5:0] src_a;
    logic [5:0] src_b;
    logic [5:0] sh;
    logic [1:0] wsel;
  } instr_t;

  typedef struct packed {
    logic       start;
    logic [2:0] op;
    logic [5:0] sh;
    logic [1:0] wsel;
  } alu_ctl_t;

  function automatic logic [63:0] mag64(input logic [63:0] x);
    return x[63] ? (64'd0 - x) : x;
  endfunction

  // Signed value from sign and magnitude, saturated to w bits, sign-extended.
  function automatic logic [63:0] sat_mag(input logic neg, input logic [127:0] m,
                                          input logic [6:0] w);
    logic [127:0] lim;
    logic [127:0] r;
    lim = 128'd1 << (w - 7'd1);
    if (!neg) begin
      r = (m > lim - 128'd1) ? lim - 128'd1 : m;
    end else begin
      r = (m >= lim) ? (128'd0 - lim) : (128'd0 - m);
    end
    return r[63:0];
  endfunction

  function automatic instr_t ins(input logic [2:0] op, input logic [5:0] d,
                                 input logic [5:0] a, input logic [5:0] b,
                                 input logic [5:0] sh, input logic [1:0] w);
    instr_t i;
    i.op    = op;
    i.dst   = d[4:0];
    i.src_a = a;
    i.src_b = b;
    i.sh    = sh;
    i.wsel  = w;
    return i;
  endfunction

  function automatic instr_t prog_rom(input logic [6:0] pc);
    instr_t r;
    unique case (pc)
      // Filter reset: powers of T, initial covariance, zero estimates.
      7'd0:  r = ins(OP_MUL, R09, S_T, S_T, 6'd24, W_COV);
      7'd1:  r = ins(OP_MUL, R10, R09, S_T, 6'd24, W_COV);
      7'd2:  r = ins(OP_MUL, R11, R10, S_T, 6'd24, W_COV);
      7'd3:  r = ins(OP_MUL, R12, R11, S_T, 6'd24, W_COV);
      7'd4:  r = ins(OP_MUL, R13, R12, S_T, 6'd24, W_COV);
      7'd5:  r = ins(OP_MUL, R14, S_VS, R13, 6'd24, W_COV);
      7'd6:  r = ins(OP_DIV, R14, R14, S_C36, 6'd0, W_COV);
      7'd7:  r = ins(OP_ADD, R_P00, S_VE, R14, 6'd0, W_COV);
      7'd8:  r = ins(OP_MUL, R14, S_VS, R12, 6'd24, W_COV);
      7'd9:  r = ins(OP_DIV, R_P01, R14, S_C12, 6'd0, W_COV);
      7'd10: r = ins(OP_MUL, R14, S_VS, R11, 6'd24, W_COV);
      7'd11: r = ins(OP_DIV, R_P02, R14, S_C6, 6'd0, W_COV);
      7'd12: r = ins(OP_DIV, R15, S_VE, S_T, 6'd24, W_COV);
      7'd13: r = ins(OP_DIV, R14, R14, S_C4, 6'd0, W_COV);
      7'd14: r = ins(OP_ADD, R_P11, R15, R14, 6'd0, W_COV);
      7'd15: r = ins(OP_MUL, R14, S_VS, R10, 6'd24, W_COV);
      7'd16: r = ins(OP_DIV, R_P12, R14, S_C2, 6'd0, W_COV);
      7'd17: r = ins(OP_DIV, R_P22, S_VE, R09, 6'd24, W_COV);
      7'd18: r = ins(OP_ADD, R_S, S_ZERO, S_ZERO, 6'd0, W_EST);
      7'd19: r = ins(OP_ADD, R_V, S_ZERO, S_ZERO, 6'd0, W_EST);
      7'd20: r = ins(OP_ADD, R_A, S_ZERO, S_ZERO, 6'd0, W_EST);
      7'd21: r = ins(OP_END, R_P00, S_ZERO, S_ZERO, 6'd0, W_64);
      // Measurement: prediction.
      7'd24: r = ins(OP_MUL, R09, S_T16, S_T16, 6'd7, W_64);
      7'd25: r = ins(OP_MUL, R10, R_V, S_T16, 6'd16, W_EST);
      7'd26: r = ins(OP_ADD, R10, R_S, R10, 6'd0, W_EST);
      7'd27: r = ins(OP_MUL, R11, R_A, R09, 6'd24, W_EST);
      7'd28: r = ins(OP_ADD, R_S, R10, R11, 6'd0, W_EST);
      7'd29: r = ins(OP_MUL, R10, R_A, S_T16, 6'd16, W_EST);
      7'd30: r = ins(OP_ADD, R_V, R_V, R10, 6'd0, W_EST);
      7'd31: r = ins(OP_CMP, R_P00, R_V, S_THRSH, 6'd0, W_64);
      7'd32: r = ins(OP_MUL, R12, R_P22, R09, 6'd24, W_COV);
      7'd33: r = ins(OP_MUL, R13, R_P22, S_T, 6'd24, W_COV);
      7'd34: r = ins(OP_MUL, R14, R_P12, S_T, 6'd24, W_COV);
      7'd35: r = ins(OP_ADD, R15, R14, R14, 6'd0, W_COV);
      7'd36: r = ins(OP_ADD, R15, R12, R15, 6'd0, W_COV);
      7'd37: r = ins(OP_ADD, R16, R_P02, R_P02, 6'd0, W_COV);
      7'd38: r = ins(OP_ADD, R15, R15, R16, 6'd0, W_COV);
      7'd39: r = ins(OP_MUL, R15, R15, R09, 6'd24, W_COV);
      7'd40: r = ins(OP_MUL, R16, R_P11, S_T, 6'd24, W_COV);
      7'd41: r = ins(OP_ADD, R17, R_P01, R_P01, 6'd0, W_COV);
      7'd42: r = ins(OP_ADD, R16, R16, R17, 6'd0, W_COV);
      7'd43: r = ins(OP_MUL, R16, R16, S_T, 6'd24, W_COV);
      7'd44: r = ins(OP_ADD, R16, R16, R_P00, 6'd0, W_COV);
      7'd45: r = ins(OP_ADD, R18, R15, R16, 6'd0, W_COV);
      7'd46: r = ins(OP_ADD, R15, R_P12, R_P12, 6'd0, W_COV);
      7'd47: r = ins(OP_ADD, R15, R13, R15, 6'd0, W_COV);
      7'd48: r = ins(OP_MUL, R15, R15, S_T, 6'd24, W_COV);
      7'd49: r = ins(OP_ADD, R19, R15, R_P11, 6'd0, W_COV);
      7'd50: r = ins(OP_MUL, R15, S_VM, S_T, 6'd24, W_COV);
      7'd51: r = ins(OP_MUL, R15, R15, S_T, 6'd24, W_COV);
      7'd52: r = ins(OP_ADD, R20, R_P22, R15, 6'd0, W_COV);
      7'd53: r = ins(OP_ADD, R15, R13, R_P12, 6'd0, W_COV);
      7'd54: r = ins(OP_MUL, R15, R15, R09, 6'd24, W_COV);
      7'd55: r = ins(OP_ADD, R16, R14, R_P02, 6'd0, W_COV);
      7'd56: r = ins(OP_ADD, R16, R16, R_P11, 6'd0, W_COV);
      7'd57: r = ins(OP_MUL, R16, R16, S_T, 6'd24, W_COV);
      7'd58: r = ins(OP_ADD, R15, R15, R16, 6'd0, W_COV);
      7'd59: r = ins(OP_ADD, R21, R15, R_P01, 6'd0, W_COV);
      7'd60: r = ins(OP_ADD, R15, R12, R14, 6'd0, W_COV);
      7'd61: r = ins(OP_ADD, R22, R15, R_P02, 6'd0, W_COV);
      7'd62: r = ins(OP_ADD, R23, R13, R_P12, 6'd0, W_COV);
      // Measurement: gain and update.
      7'd63: r = ins(OP_ADD, R15, R18, S_VE, 6'd0, W_COV);
      7'd64: r = ins(OP_RCP, R16, S_TWO62, R15, 6'd0, W_64);
      7'd65: r = ins(OP_MUL, R24, R18, R16, 6'd30, W_64);
      7'd66: r = ins(OP_MUL, R25, R21, R16, 6'd30, W_64);
      7'd67: r = ins(OP_MUL, R26, R22, R16, 6'd30, W_64);
      7'd68: r = ins(OP_SUB, R27, S_MEAS, R_S, 6'd0, W_64);
      7'd69: r = ins(OP_MUL, R15, R24, R27, 6'd32, W_EST);
      7'd70: r = ins(OP_ADD, R_S, R_S, R15, 6'd0, W_EST);
      7'd71: r = ins(OP_MUL, R15, R25, R27, 6'd32, W_EST);
      7'd72: r = ins(OP_ADD, R_V, R_V, R15, 6'd0, W_EST);
      7'd73: r = ins(OP_MUL, R15, R26, R27, 6'd32, W_EST);
      7'd74: r = ins(OP_ADD, R_A, R_A, R15, 6'd0, W_EST);
      7'd75: r = ins(OP_SUB, R28, S_ONE32, R24, 6'd0, W_64);
      7'd76: r = ins(OP_MUL, R_P00, R28, R18, 6'd32, W_COV);
      7'd77: r = ins(OP_MUL, R_P01, R28, R21, 6'd32, W_COV);
      7'd78: r = ins(OP_MUL, R_P02, R28, R22, 6'd32, W_COV);
      7'd79: r = ins(OP_MUL, R15, R25, R21, 6'd32, W_COV);
      7'd80: r = ins(OP_SUB, R_P11, R19, R15, 6'd0, W_COV);
      7'd81: r = ins(OP_MUL, R15, R25, R22, 6'd32, W_COV);
      7'd82: r = ins(OP_SUB, R_P12, R23, R15, 6'd0, W_COV);
      7'd83: r = ins(OP_MUL, R15, R26, R22, 6'd32, W_COV);
      7'd84: r = ins(OP_SUB, R_P22, R20, R15, 6'd0, W_COV);
      default: r = ins(OP_END, R_P00, S_ZERO, S_ZERO, 6'd0, W_64);
    endcase
    return r;
  endfunction

endpackage

@@ hw/rtl/kat_alu.sv @@
// ----------------------------------------------------------------------------
// Kalman altitude tracker arithmetic unit
// Shared saturating unit: multiply with rounding (four 32x32 partial products),
// add, subtract, compare, and a restoring divider one quotient bit a cycle.
// ----------------------------------------------------------------------------
module kat_alu #(
  parameter int ESTIMATE_WIDTH   = 32,
  parameter int COVARIANCE_WIDTH = 48
) (
  input  logic               clk,
  input  logic               rst_n,
  input  kat_pkg::alu_ctl_t  ctl,
  input  logic [63:0]        opa,
  input  logic [63:0]        opb,
  output logic               done,
  output logic [63:0]        res
);

  localparam logic [2:0] A_IDLE = 3'd0;
  localparam logic [2:0] A_MUL  = 3'd1;
  localparam logic [2:0] A_RND  = 3'd2;
  localparam logic [2:0] A_DIV  = 3'd3;
  localparam logic [2:0] A_SAT  = 3'd4;

  logic [2:0]   state_r;
  logic         done_r;
  logic [63:0]  res_r;
  logic [5:0]   cnt_r;
  logic [5:0]   sh_r;
  logic [1:0]   wsel_r;
  logic         neg_r;
  logic [63:0]  ma_r, mb_r;
  logic [63:0]  pp_r;
  logic [1:0]   pp_off_r;
  logic [127:0] acc_r;
  logic [127:0] mag_r;
  logic [63:0]  rem_r, lo_r, q_r, dm_r;

  logic [64:0]  sum;
  logic [63:0]  ua, ub;
  logic [127:0] dvd;
  logic [63:0]  pp_nxt;
  logic [1:0]   pp_off_nxt;
  logic [127:0] rnd;
  logic [64:0]  trial, diff;
  logic         qbit;
  logic [6:0]   wid;

  always_comb begin
    ua  = kat_pkg::mag64(opa);
    ub  = kat_pkg::mag64(opb);
    dvd = {64'd0, ua} << ctl.sh;
    if (ctl.op == kat_pkg::OP_SUB) begin
      sum = {opa[63], opa} - {opb[63], opb};
    end else begin
      sum = {opa[63], opa} + {opb[63], opb};
    end
    pp_nxt = (cnt_r[1] ? ma_r[63:32] : ma_r[31:0]) * (cnt_r[0] ? mb_r[63:32] : mb_r[31:0]);
    pp_off_nxt = {1'b0, cnt_r[1]} + {1'b0, cnt_r[0]};
    rnd   = acc_r + (128'd1 << (sh_r - 6'd1));
    trial = {rem_r, lo_r[63]};
    qbit  = (trial >= {1'b0, dm_r});
    diff  = trial - {1'b0, dm_r};
    case (wsel_r)
      kat_pkg::W_EST: wid = 7'(ESTIMATE_WIDTH);
      kat_pkg::W_COV: wid = 7'(COVARIANCE_WIDTH);
      default:        wid = 7'd64;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= A_IDLE;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      unique case (state_r)
        A_IDLE: begin
          if (ctl.start) begin
            sh_r   <= ctl.sh;
            wsel_r <= ctl.wsel;
            cnt_r  <= 6'd0;
            unique case (ctl.op) inside
              kat_pkg::OP_MUL: begin
                ma_r    <= ua;
                mb_r    <= ub;
                neg_r   <= opa[63] ^ opb[63];
                acc_r   <= 128'd0;
                state_r <= A_MUL;
              end
              kat_pkg::OP_ADD, kat_pkg::OP_SUB: begin
                neg_r   <= sum[64];
                mag_r   <= {63'd0, sum[64] ? (65'd0 - sum) : sum};
                state_r <= A_SAT;
              end
              kat_pkg::OP_CMP: begin
                neg_r   <= 1'b0;
                mag_r   <= {127'd0, $signed(opa) > $signed(opb)};
                state_r <= A_SAT;
              end
              kat_pkg::OP_DIV, kat_pkg::OP_RCP: begin
                // A reciprocal of a non-positive value gives zero gains.
                if (opa == 64'd0 || (ctl.op == kat_pkg::OP_RCP && $signed(opb) <= 0)) begin
                  neg_r   <= 1'b0;
                  mag_r   <= 128'd0;
                  state_r <= A_SAT;
                end else if (ub == 64'd0 || dvd[127:64] >= ub) begin
                  neg_r   <= opa[63] ^ opb[63];
                  mag_r   <= {64'd0, {64{1'b1}}};
                  state_r <= A_SAT;
                end else begin
                  neg_r   <= opa[63] ^ opb[63];
                  rem_r   <= dvd[127:64];
                  lo_r    <= dvd[63:0];
                  dm_r    <= ub;
                  q_r     <= 64'd0;
                  state_r <= A_DIV;
                end
              end
              default: state_r <= A_IDLE;
            endcase
          end
        end
        A_MUL: begin
          if (cnt_r != 6'd4) begin
            pp_r     <= pp_nxt;
            pp_off_r <= pp_off_nxt;
          end
          if (cnt_r != 6'd0) begin
            acc_r <= acc_r + ({64'd0, pp_r} << {pp_off_r, 5'd0});
          end
          cnt_r <= cnt_r + 6'd1;
          if (cnt_r == 6'd4) begin
            state_r <= A_RND;
          end
        end
        A_RND: begin
          mag_r   <= rnd >> sh_r;
          state_r <= A_SAT;
        end
        A_DIV: begin
          rem_r <= qbit ? diff[63:0] : trial[63:0];
          lo_r  <= {lo_r[62:0], 1'b0};
          q_r   <= {q_r[62:0], qbit};
          cnt_r <= cnt_r + 6'd1;
          if (cnt_r == 6'd63) begin
            mag_r   <= {64'd0, q_r[62:0], qbit};
            state_r <= A_SAT;
          end
        end
        A_SAT: begin
          res_r   <= kat_pkg::sat_mag(neg_r, mag_r, wid);
          done_r  <= 1'b1;
          state_r <= A_IDLE;
        end
        default: state_r <= A_IDLE;
      endcase
    end
  end

  assign done = done_r;
  assign res  = res_r;

endmodule

@@ hw/rtl/kat_regfile.sv @@
// ----------------------------------------------------------------------------
// Kalman altitude tracker register file
// Working store for state, covariance and temporaries: one write port and two
// read ports with registered read data.
// ----------------------------------------------------------------------------
module kat_regfile (
  input  logic        clk,
  input  logic        we,
  input  logic [4:0]  waddr,
  input  logic [63:0] wdata,
  input  logic [4:0]  raddr_a,
  input  logic [4:0]  raddr_b,
  output logic [63:0] rdata_a,
  output logic [63:0] rdata_b
);

  logic [63:0] mem_r [32];
  logic [63:0] rda_r, rdb_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rda_r <= mem_r[raddr_a];
    rdb_r <= mem_r[raddr_b];
  end

  assign rdata_a = rda_r;
  assign rdata_b = rdb_r;

endmodule

@@ hw/rtl/kalman_altitude_tracker_unit.sv @@
// Processing: a measurement word or a filter reset word steps through the
// microprogram on the shared arithmetic unit, where the multiplier and the
// divider take longest.
// Throughput: one word at a time; the next is taken once the last has finished.
// Reset: synchronous, active low; afterwards the reset program runs to load
// the initial covariance, and in_tready stays low meanwhile.
// ----------------------------------------------------------------------------
// Kalman altitude tracker
// Three-state position, velocity and acceleration filter driven by position
// measurements, computed by a microcoded sequencer over one shared unit.
// ----------------------------------------------------------------------------
module kalman_altitude_tracker_unit #(
  parameter int ESTIMATE_WIDTH   = 32,
  parameter int COVARIANCE_WIDTH = 48
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] measured_position
  input  logic        in_tuser,   // [0] command
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [95:0] out_tdata,  // [31:0] position, [63:32] velocity, [95:64] acceleration
  output logic        out_tuser,  // [0] transonic_mode
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [47:0] cfg_wdata
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_FETCH = 2'd1;
  localparam logic [1:0] S_OPER  = 2'd2;
  localparam logic [1:0] S_WAIT  = 2'd3;

  logic [1:0]  state_r;
  logic [6:0]  pc_r;
  logic        init_r;
  logic        trans_r;
  logic [31:0] meas_r;
  logic [31:0] ts_r;
  logic [47:0] mv_r, vsub_r, vtra_r;
  logic [30:0] thr_r;
  logic [31:0] est_s_r, est_v_r, est_a_r;
  logic        out_tvalid_r;
  logic [95:0] out_tdata_r;
  logic        out_tuser_r;

  kat_pkg::instr_t   instr;
  kat_pkg::alu_ctl_t alu_ctl;
  logic [63:0] rd_a, rd_b, opa, opb, alu_res;
  logic        alu_done;
  logic        rf_we;
  logic        out_free;
  logic [63:0] ve, vs, vm;

  assign instr    = kat_pkg::prog_rom(pc_r);
  assign out_free = !out_tvalid_r || out_tready;
  assign rf_we    = (state_r == S_WAIT) && alu_done && (instr.op != kat_pkg::OP_CMP);

  assign ve = kat_pkg::sat_mag(1'b0, {80'd0, mv_r}, 7'(COVARIANCE_WIDTH));
  assign vs = kat_pkg::sat_mag(1'b0, {80'd0, vsub_r}, 7'(COVARIANCE_WIDTH));
  assign vm = trans_r ? kat_pkg::sat_mag(1'b0, {80'd0, vtra_r}, 7'(COVARIANCE_WIDTH)) : vs;

  function automatic logic [63:0] src_val(input logic [5:0] code, input logic [63:0] rd);
    logic [63:0] v;
    if (!code[5]) begin
      v = rd;
    end else begin
      unique case (code)
        kat_pkg::S_T16:   v = {32'd0, ts_r};
        kat_pkg::S_T:     v = {24'd0, ts_r, 8'd0};
        kat_pkg::S_VE:    v = ve;
        kat_pkg::S_VS:    v = vs;
        kat_pkg::S_VM:    v = vm;
        kat_pkg::S_MEAS:  v = {{32{meas_r[31]}}, meas_r};
        kat_pkg::S_C36:   v = 64'd36;
        kat_pkg::S_C12:   v = 64'd12;
        kat_pkg::S_C6:    v = 64'd6;
        kat_pkg::S_C4:    v = 64'd4;
        kat_pkg::S_C2:    v = 64'd2;
        kat_pkg::S_ONE32: v = 64'd1 << 32;
        kat_pkg::S_TWO62: v = 64'd1 << 62;
        kat_pkg::S_THRSH: v = {33'd0, thr_r};
        default:          v = 64'd0;
      endcase
    end
    return v;
  endfunction

  always_comb begin
    opa = src_val(instr.src_a, rd_a);
    opb = src_val(instr.src_b, rd_b);
    alu_ctl.start = (state_r == S_OPER);
    alu_ctl.op    = instr.op;
    alu_ctl.sh    = instr.sh;
    alu_ctl.wsel  = instr.wsel;
  end

  kat_regfile u_rf (
    .clk     (clk),
    .we      (rf_we),
    .waddr   (instr.dst),
    .wdata   (alu_res),
    .raddr_a (instr.src_a[4:0]),
    .raddr_b (instr.src_b[4:0]),
    .rdata_a (rd_a),
    .rdata_b (rd_b)
  );

  kat_alu #(
    .ESTIMATE_WIDTH   (ESTIMATE_WIDTH),
    .COVARIANCE_WIDTH (COVARIANCE_WIDTH)
  ) u_alu (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (alu_ctl),
    .opa   (opa),
    .opb   (opb),
    .done  (alu_done),
    .res   (alu_res)
  );

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ts_r   <= 32'd3277;
      mv_r   <= 48'd16777216;
      vsub_r <= 48'd16777216;
      vtra_r <= 48'd16777216;
      thr_r  <= 31'd11141120;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        kat_pkg::CFG_TIME_STEP:   ts_r   <= cfg_wdata[31:0];
        kat_pkg::CFG_MEAS_VAR:    mv_r   <= cfg_wdata;
        kat_pkg::CFG_VAR_SUB:     vsub_r <= cfg_wdata;
        kat_pkg::CFG_VAR_TRA:     vtra_r <= cfg_wdata;
        kat_pkg::CFG_SPEED_THRSH: thr_r  <= cfg_wdata[30:0];
        default: ;
      endcase
    end
  end

  // Copies of the estimates, kept as they are written to the register file.
  always_ff @(posedge clk) begin
    if (rf_we) begin
      if (instr.dst == kat_pkg::R_S[4:0]) est_s_r <= alu_res[31:0];
      if (instr.dst == kat_pkg::R_V[4:0]) est_v_r <= alu_res[31:0];
      if (instr.dst == kat_pkg::R_A[4:0]) est_a_r <= alu_res[31:0];
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_FETCH;
      pc_r         <= kat_pkg::PC_RESET;
      init_r       <= 1'b1;
      trans_r      <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      if (out_tvalid_r && out_tready) begin
        out_tvalid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            meas_r  <= in_tdata;
            pc_r    <= in_tuser ? kat_pkg::PC_RESET : kat_pkg::PC_MEAS;
            trans_r <= 1'b0;
            init_r  <= 1'b0;
            state_r <= S_FETCH;
          end
        end
        S_FETCH: begin
          if (instr.op == kat_pkg::OP_END) begin
            if (init_r) begin
              state_r <= S_IDLE;
            end else if (out_free) begin
              out_tvalid_r <= 1'b1;
              out_tdata_r  <= {est_a_r, est_v_r, est_s_r};
              out_tuser_r  <= trans_r;
              state_r      <= S_IDLE;
            end
          end else begin
            state_r <= S_OPER;
          end
        end
        S_OPER: state_r <= S_WAIT;
        S_WAIT: begin
          if (alu_done) begin
            if (instr.op == kat_pkg::OP_CMP) begin
              trans_r <= alu_res[0];
            end
            pc_r    <= pc_r + 7'd1;
            state_r <= S_FETCH;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

`ifndef ASSERT_OFF
  a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    alu_done |-> state_r == S_WAIT)
    else $error("arithmetic unit finished outside the wait state");

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (state_r == S_FETCH && !in_tready))
    else $error("accepted word did not start the microprogram");

  a_reset_busy: assert property (@(posedge clk)
    !rst_n |=> !in_tready)
    else $error("ready raised before the reset program ran");
`endif

endmodule

@@ bench/tb_kalman_altitude_tracker_unit.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Kalman altitude tracker testbench
// Streams measurement and filter reset words through the tracker under several
// register settings, predicts every estimate word in fixed point alongside the
// block and compares each returned word field by field, in order.
// ----------------------------------------------------------------------------
module tb_kalman_altitude_tracker_unit;
  import kat_pkg::*;

  localparam int EST_W = 32;
  localparam int COV_W = 48;
  localparam int CYCLE_LIMIT = 2500000;

  typedef struct {
    logic [31:0] pos;
    logic [31:0] vel;
    logic [31:0] acc;
    logic        trans;
  } estimate_t;

  class altitude_scoreboard;
    logic [31:0] time_step;
    logic [47:0] meas_var, var_sub, var_tra;
    logic [30:0] speed_thr;
    longint      pos_st, vel_st, acc_st;
    longint      cov[6];
    estimate_t   estimate_q[$];
    int          errors;

    function new();
      time_step = 32'd3277;
      meas_var  = 48'd16777216;
      var_sub   = 48'd16777216;
      var_tra   = 48'd16777216;
      speed_thr = 31'd11141120;
      errors    = 0;
      reload_filter();
    endfunction

    function logic [63:0] mag(longint a);
      logic [63:0] u;
      u = a;
      return (a < 0) ? 64'd0 - u : u;
    endfunction

    // Signed value from sign and magnitude, saturated to w bits.
    function longint sat(bit neg, logic [127:0] m, int w);
      logic [127:0] lim;
      lim = 128'd1 << (w - 1);
      if (!neg) return (m > lim - 1) ? longint'(lim - 1) : longint'(m[63:0]);
      if (m >= lim) return -longint'(lim[63:0]);
      return -longint'(m[63:0]);
    endfunction

    function longint mul_rnd(longint a, longint b, int sh, int w);
      logic [127:0] p;
      p = {64'd0, mag(a)} * {64'd0, mag(b)};
      p = p + (128'd1 << (sh - 1));
      return sat((a < 0) != (b < 0), p >> sh, w);
    endfunction

    function longint add_sat(longint a, longint b, int w);
      logic signed [65:0] r;
      logic [127:0] m;
      r = a;
      r = r + b;
      m = (r < 0) ? -r : r;
      return sat(r < 0, m, w);
    endfunction

    function longint sub_sat(longint a, longint b, int w);
      logic signed [65:0] r;
      logic [127:0] m;
      r = a;
      r = r - b;
      m = (r < 0) ? -r : r;
      return sat(r < 0, m, w);
    endfunction

    function logic [63:0] div_floor(logic [127:0] num, logic [63:0] d);
      logic [127:0] q;
      if (d == 0 || num[127:64] >= d) return '1;
      q = num / {64'd0, d};
      return q[63:0];
    endfunction

    // (n << k) / d truncated toward zero; a zero divisor saturates by sign.
    function longint div_sh(longint n, longint d, int k, int w);
      if (n == 0) return 0;
      return sat((n < 0) != (d < 0), {64'd0, div_floor({64'd0, mag(n)} << k, mag(d))}, w);
    endfunction

    function longint var_q(logic [47:0] raw);
      return sat(1'b0, {80'd0, raw}, COV_W);
    endfunction

    function void set_reg(logic [2:0] idx, logic [47:0] val);
      case (idx)
        CFG_TIME_STEP:   time_step = val[31:0];
        CFG_MEAS_VAR:    meas_var  = val;
        CFG_VAR_SUB:     var_sub   = val;
        CFG_VAR_TRA:     var_tra   = val;
        CFG_SPEED_THRSH: speed_thr = val[30:0];
        default: ;
      endcase
    endfunction

    function void reload_filter();
      longint t, ve, vs, t2, t3, t4, t5, t6;
      t  = longint'({32'd0, time_step}) << 8;
      ve = var_q(meas_var);
      vs = var_q(var_sub);
      t2 = mul_rnd(t, t, 24, COV_W);
      t3 = mul_rnd(t2, t, 24, COV_W);
      t4 = mul_rnd(t3, t, 24, COV_W);
      t5 = mul_rnd(t4, t, 24, COV_W);
      t6 = mul_rnd(t5, t, 24, COV_W);
      pos_st = 0;
      vel_st = 0;
      acc_st = 0;
      cov[0] = add_sat(ve, div_sh(mul_rnd(vs, t6, 24, COV_W), 36, 0, COV_W), COV_W);
      cov[1] = div_sh(mul_rnd(vs, t5, 24, COV_W), 12, 0, COV_W);
      cov[2] = div_sh(mul_rnd(vs, t4, 24, COV_W), 6, 0, COV_W);
      cov[3] = add_sat(div_sh(ve, t, 24, COV_W),
                       div_sh(mul_rnd(vs, t4, 24, COV_W), 4, 0, COV_W), COV_W);
      cov[4] = div_sh(mul_rnd(vs, t3, 24, COV_W), 2, 0, COV_W);
      cov[5] = div_sh(ve, t2, 24, COV_W);
    endfunction

    function longint cm(longint a, longint b);
      return mul_rnd(a, b, 24, COV_W);
    endfunction

    function longint ca(longint a, longint b);
      return add_sat(a, b, COV_W);
    endfunction

    function bit track_measurement(logic [31:0] raw);
      longint meas, t16, t, th, s, v, a, vm, c1, c2, p12t;
      longint h00, h01, h02, h11, h12, h22, sv, rc, k0, k1, k2, inn, raux;
      bit trans;
      meas = longint'(signed'(raw));
      t16  = longint'({32'd0, time_step});
      t    = t16 << 8;
      th   = mul_rnd(t16, t16, 7, 64);
      s = add_sat(add_sat(pos_st, mul_rnd(vel_st, t16, 16, EST_W), EST_W),
                  mul_rnd(acc_st, th, 24, EST_W), EST_W);
      v = add_sat(vel_st, mul_rnd(acc_st, t16, 16, EST_W), EST_W);
      a = acc_st;
      trans = v > longint'({33'd0, speed_thr});
      vm = var_q(trans ? var_tra : var_sub);
      c1   = cm(cov[5], th);
      c2   = cm(cov[5], t);
      p12t = cm(cov[4], t);
      h00 = ca(cm(ca(ca(c1, ca(p12t, p12t)), ca(cov[2], cov[2])), th),
               ca(cm(ca(cm(cov[3], t), ca(cov[1], cov[1])), t), cov[0]));
      h11 = ca(cm(ca(c2, ca(cov[4], cov[4])), t), cov[3]);
      h22 = ca(cov[5], cm(cm(vm, t), t));
      h01 = ca(ca(cm(ca(c2, cov[4]), th), cm(ca(ca(p12t, cov[2]), cov[3]), t)), cov[1]);
      h02 = ca(ca(c1, p12t), cov[2]);
      h12 = ca(c2, cov[4]);
      sv = ca(h00, var_q(meas_var));
      k0 = 0;
      k1 = 0;
      k2 = 0;
      // A non-positive innovation variance leaves the prediction untouched.
      if (sv > 0) begin
        rc = longint'(div_floor(128'd1 << 62, sv));
        k0 = mul_rnd(h00, rc, 30, 64);
        k1 = mul_rnd(h01, rc, 30, 64);
        k2 = mul_rnd(h02, rc, 30, 64);
      end
      inn = sub_sat(meas, s, 64);
      pos_st = add_sat(s, mul_rnd(k0, inn, 32, EST_W), EST_W);
      vel_st = add_sat(v, mul_rnd(k1, inn, 32, EST_W), EST_W);
      acc_st = add_sat(a, mul_rnd(k2, inn, 32, EST_W), EST_W);
      raux = sub_sat(longint'(1) << 32, k0, 64);
      cov[0] = mul_rnd(raux, h00, 32, COV_W);
      cov[1] = mul_rnd(raux, h01, 32, COV_W);
      cov[2] = mul_rnd(raux, h02, 32, COV_W);
      cov[3] = sub_sat(h11, mul_rnd(k1, h01, 32, COV_W), COV_W);
      cov[4] = sub_sat(h12, mul_rnd(k1, h02, 32, COV_W), COV_W);
      cov[5] = sub_sat(h22, mul_rnd(k2, h02, 32, COV_W), COV_W);
      return trans;
    endfunction

    function void note_word(logic cmd, logic [31:0] raw);
      estimate_t e;
      e.trans = 1'b0;
      if (cmd) reload_filter();
      else e.trans = track_measurement(raw);
      e.pos = pos_st[31:0];
      e.vel = vel_st[31:0];
      e.acc = acc_st[31:0];
      estimate_q.push_back(e);
    endfunction

    function void check_word(logic [95:0] data, logic user);
      estimate_t e;
      if (estimate_q.size() == 0) begin
        $display("%t: unexpected estimate word %h / %b", $time, data, user);
        errors++;
        return;
      end
      e = estimate_q.pop_front();
      if (data[31:0] !== e.pos) begin
        $display("%t: position expected %h actual %h", $time, e.pos, data[31:0]);
        errors++;
      end
      if (data[63:32] !== e.vel) begin
        $display("%t: velocity expected %h actual %h", $time, e.vel, data[63:32]);
        errors++;
      end
      if (data[95:64] !== e.acc) begin
        $display("%t: acceleration expected %h actual %h", $time, e.acc, data[95:64]);
        errors++;
      end
      if (user !== e.trans) begin
        $display("%t: transonic flag expected %b actual %b", $time, e.trans, user);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;
  logic        in_tuser = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [95:0] out_tdata;
  logic        out_tuser;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_addr = CFG_TIME_STEP;
  logic [47:0] cfg_wdata = '0;

  altitude_scoreboard sb = new();
  int unsigned cycles = 0;
  int unsigned words_in = 0;
  logic [31:0] track_pos = '0;
  logic [31:0] track_slope = '0;

  always #5 clk = ~clk;

  kalman_altitude_tracker_unit dut (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
    if (rst_n && in_tvalid && in_tready) begin
      sb.note_word(in_tuser, in_tdata);
      words_in <= words_in + 1;
    end
    if (rst_n && out_tvalid && out_tready) sb.check_word(out_tdata, out_tuser);
  end

  // Receiver: alternating stretches of full readiness and random stalls, plus
  // one long hold-off early on so that the block backs up.
  initial begin
    int  span;
    bit  stall_mode;
    bit  held;
    held = 0;
    forever begin
      span = $urandom_range(20, 400);
      stall_mode = $urandom_range(0, 1);
      repeat (span) begin
        @(posedge clk);
        if (!held && words_in >= 40) begin
          held = 1;
          out_tready <= 1'b0;
          repeat (3000) @(posedge clk);
        end
        out_tready <= stall_mode ? ($urandom_range(0, 3) == 0) : 1'b1;
      end
    end
  end

  task automatic send_word(logic cmd, logic [31:0] raw);
    @(posedge clk);
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= raw;
    @(negedge clk);
    while (!in_tready) @(negedge clk);
  endtask

  task automatic pause_sender(int unsigned n);
    @(posedge clk);
    in_tvalid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic wait_drained();
    pause_sender(0);
    while (sb.estimate_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_regs(logic [31:0] ts, logic [47:0] ve, logic [47:0] vs,
                            logic [47:0] vt, logic [30:0] thr);
    logic [47:0] vals[5];
    vals = '{{16'd0, ts}, ve, vs, vt, {17'd0, thr}};
    for (int i = 0; i < 5; i++) begin
      @(posedge clk);
      cfg_we    <= 1'b1;
      cfg_addr  <= 3'(i);
      cfg_wdata <= vals[i];
      sb.set_reg(3'(i), vals[i]);
    end
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Mostly a noisy track with a random climb rate, so that the filter settles
  // and crosses the speed threshold; the rest is full-range noise and resets.
  task automatic random_words(int n);
    int k;
    k = 0;
    while (k < n) begin
      repeat ($urandom_range(1, 12)) begin
        if ($urandom_range(0, 99) < 3) begin
          send_word(1'b1, $urandom);
          track_pos = '0;
        end else if ($urandom_range(0, 99) < 10) begin
          send_word(1'b0, $urandom);
        end else begin
          if ($urandom_range(0, 19) == 0)
            track_slope = 32'($signed($urandom_range(0, 2000000)) - 600000);
          track_pos = track_pos + track_slope;
          send_word(1'b0, track_pos + 32'($signed($urandom_range(0, 131072)) - 65536));
        end
        k++;
      end
      if ($urandom_range(0, 2) != 0) pause_sender($urandom_range(0, 40));
    end
  endtask

  initial begin
    logic [31:0] ramp;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    while (!in_tready) @(negedge clk);

    // Directed words under the reset settings.
    send_word(1'b0, 32'h7fffffff);
    send_word(1'b0, 32'h80000000);
    send_word(1'b0, 32'h00000000);
    send_word(1'b0, 32'hffffffff);
    send_word(1'b1, 32'hffffffff);
    ramp = '0;
    for (int i = 0; i < 10; i++) begin
      ramp = ramp + 32'd800000;
      send_word(1'b0, ramp);
    end
    send_word(1'b1, 32'h0);
    send_word(1'b0, 32'h55555555);
    send_word(1'b0, 32'haaaaaaaa);
    wait_drained();

    // Largest values: variances above the covariance range, longest step.
    write_regs('1, '1, '1, '1, '1);
    send_word(1'b1, 32'h0);
    send_word(1'b0, 32'h7fffffff);
    send_word(1'b0, 32'h80000000);
    random_words(60);
    wait_drained();

    // Smallest values: zero variances give a zero innovation variance.
    write_regs(32'd1, '0, '0, '0, '0);
    send_word(1'b1, 32'h0);
    send_word(1'b0, 32'h12345678);
    send_word(1'b0, 32'h80000000);
    random_words(60);
    wait_drained();

    // Zero measurement variance only, short step.
    write_regs(32'd655, '0, 48'd16777216, 48'd167772160, 31'd6553600);
    send_word(1'b1, 32'h0);
    random_words(80);
    wait_drained();

    for (int p = 0; p < 4; p++) begin
      write_regs($urandom_range(100, 40000),
                 {$urandom_range(0, 65535), 32'($urandom)} >> $urandom_range(0, 24),
                 {$urandom_range(0, 65535), 32'($urandom)} >> $urandom_range(0, 28),
                 {$urandom_range(0, 65535), 32'($urandom)} >> $urandom_range(0, 28),
                 31'($urandom_range(0, 30000000)));
      send_word(1'b1, 32'h0);
      random_words(110);
      wait_drained();
    end

    // Back to the reset values for a final stretch of tracking.
    write_regs(32'd3277, 48'd16777216, 48'd16777216, 48'd16777216, 31'd11141120);
    send_word(1'b1, 32'h0);
    random_words(130);
    wait_drained();
    repeat (600) @(posedge clk);

    if (sb.errors == 0 && sb.estimate_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hw/rtl/kat_pkg.sv
hw/rtl/kat_alu.sv
hw/rtl/kat_regfile.sv
hw/rtl/kalman_altitude_tracker_unit.sv
bench/tb_kalman_altitude_tracker_unit.sv
